// ===== sv/pick_place_arm_sequencer_core_macros.svh =====
// assertion helpers for the checker file
`ifndef PICK_PLACE_ARM_SEQUENCER_CORE_MACROS_SVH
`define PICK_PLACE_ARM_SEQUENCER_CORE_MACROS_SVH

// condition holds in the same cycle as the antecedent
`define PPAS_ASSERT_NOW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the antecedent
`define PPAS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ppas_pkg.sv =====
`default_nettype none

package ppas_pkg;

    // field widths
    localparam int ANGLE_W   = 8;
    localparam int FINE_W    = 12;
    localparam int TIME_W    = 16;
    localparam int ELAPSED_W = 17;
    localparam int POSE_W    = 24;
    localparam int GRIP_W    = 16;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 40;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // goal angles after reset, listed gripper, elbow, shoulder, base
    localparam logic [3:0][ANGLE_W-1:0] GOAL_RESET = {8'd0, 8'd60, 8'd90, 8'd90};

    // register reset values
    localparam logic [FINE_W-1:0] TOL_RESET     = 12'd16;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [TIME_W-1:0] RETRY_RESET   = 16'd1000;
    localparam logic [TIME_W-1:0] PULSE_RESET   = 16'd10;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_READY = 3'd1,
        PH_GRAB  = 3'd2,
        PH_LIFT  = 3'd3,
        PH_PUT   = 3'd4
    } t_phase;

    // register word indexes
    typedef enum logic [2:0] {
        REG_TOL     = 3'd0,
        REG_TIMEOUT = 3'd1,
        REG_RETRY   = 3'd2,
        REG_PULSE   = 3'd3,
        REG_READY   = 3'd4,
        REG_LIFT    = 3'd5,
        REG_PUT     = 3'd6,
        REG_GRIP    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [FINE_W-1:0]  at_target_tolerance;
        logic [TIME_W-1:0]  state_timeout_ms;
        logic [TIME_W-1:0]  idle_retry_ms;
        logic [TIME_W-1:0]  pulse_length_ms;
        logic [POSE_W-1:0]  ready_pose;
        logic [POSE_W-1:0]  lift_pose;
        logic [POSE_W-1:0]  put_pose;
        logic [GRIP_W-1:0]  grip_angles;
    } t_cfg;

    typedef struct packed {
        logic               cmd_valid;
        logic [ANGLE_W-1:0] cmd_base;
        logic [ANGLE_W-1:0] cmd_shoulder;
        logic [ANGLE_W-1:0] cmd_elbow;
        logic [FINE_W-1:0]  now_base;
        logic [FINE_W-1:0]  now_shoulder;
        logic [FINE_W-1:0]  now_elbow;
        logic [FINE_W-1:0]  now_gripper;
    } t_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] goal_base;
        logic [ANGLE_W-1:0] goal_shoulder;
        logic [ANGLE_W-1:0] goal_elbow;
        logic [ANGLE_W-1:0] goal_gripper;
        t_phase             arm_phase;
        logic               request_level;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/ppas_cfg.sv =====
`default_nettype none

module ppas_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppas_pkg::APB_AW-1:0]   paddr,
    input  wire logic [ppas_pkg::APB_DW-1:0]   pwdata,
    output logic      [ppas_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output ppas_pkg::t_cfg                     o_cfg
);
    import ppas_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.at_target_tolerance <= TOL_RESET;
            r_cfg.state_timeout_ms    <= TIMEOUT_RESET;
            r_cfg.idle_retry_ms       <= RETRY_RESET;
            r_cfg.pulse_length_ms     <= PULSE_RESET;
            r_cfg.ready_pose          <= '0;
            r_cfg.lift_pose           <= '0;
            r_cfg.put_pose            <= '0;
            r_cfg.grip_angles         <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_TOL:     r_cfg.at_target_tolerance <= pwdata[FINE_W-1:0];
                REG_TIMEOUT: r_cfg.state_timeout_ms    <= pwdata[TIME_W-1:0];
                REG_RETRY:   r_cfg.idle_retry_ms       <= pwdata[TIME_W-1:0];
                REG_PULSE:   r_cfg.pulse_length_ms     <= pwdata[TIME_W-1:0];
                REG_READY:   r_cfg.ready_pose          <= pwdata[POSE_W-1:0];
                REG_LIFT:    r_cfg.lift_pose           <= pwdata[POSE_W-1:0];
                REG_PUT:     r_cfg.put_pose            <= pwdata[POSE_W-1:0];
                REG_GRIP:    r_cfg.grip_angles         <= pwdata[GRIP_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_TOL:     prdata = {{(APB_DW-FINE_W){1'b0}}, r_cfg.at_target_tolerance};
            REG_TIMEOUT: prdata = {{(APB_DW-TIME_W){1'b0}}, r_cfg.state_timeout_ms};
            REG_RETRY:   prdata = {{(APB_DW-TIME_W){1'b0}}, r_cfg.idle_retry_ms};
            REG_PULSE:   prdata = {{(APB_DW-TIME_W){1'b0}}, r_cfg.pulse_length_ms};
            REG_READY:   prdata = {{(APB_DW-POSE_W){1'b0}}, r_cfg.ready_pose};
            REG_LIFT:    prdata = {{(APB_DW-POSE_W){1'b0}}, r_cfg.lift_pose};
            REG_PUT:     prdata = {{(APB_DW-POSE_W){1'b0}}, r_cfg.put_pose};
            REG_GRIP:    prdata = {{(APB_DW-GRIP_W){1'b0}}, r_cfg.grip_angles};
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ppas_seq.sv =====
`default_nettype none

module ppas_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  ppas_pkg::t_item      i_item,
    input  ppas_pkg::t_cfg       i_cfg,
    output ppas_pkg::t_result    o_result
);
    import ppas_pkg::*;

    // sequencer state
    t_phase                      r_phase;
    logic                        r_entry;
    logic                        r_sub;
    logic                        r_held;
    logic                        r_idle_sent;
    logic                        r_pulse_on;
    logic [2:0][ANGLE_W-1:0]     r_pick;
    logic [3:0][ANGLE_W-1:0]     r_goal;
    logic [ELAPSED_W-1:0]        r_phase_ms;
    logic [ELAPSED_W-1:0]        r_idle_ms;
    logic [TIME_W-1:0]           r_pulse_left;

    t_phase                      n_phase;
    logic                        n_entry;
    logic                        n_sub;
    logic                        n_held;
    logic                        n_idle_sent;
    logic                        n_pulse_on;
    logic [2:0][ANGLE_W-1:0]     n_pick;
    logic [3:0][ANGLE_W-1:0]     n_goal;
    logic [ELAPSED_W-1:0]        n_phase_ms;
    logic [ELAPSED_W-1:0]        n_idle_ms;
    logic [TIME_W-1:0]           n_pulse_left;

    // working values within one item
    logic                        w_held;
    logic                        w_timeout;
    t_phase                      w_phase;
    logic                        w_entry;
    logic                        w_sub;
    logic [ANGLE_W-1:0]          w_open;
    logic [ANGLE_W-1:0]          w_close;
    logic [3:0][ANGLE_W-1:0]     w_goal_pose;
    logic [3:0][ANGLE_W-1:0]     w_goal_aim;
    logic [3:0]                  w_at;
    logic                        w_arm3;
    logic                        w_go;
    t_phase                      w_go_to;
    logic                        w_start;
    logic                        w_pulse_on;
    logic [TIME_W-1:0]           w_pulse_left;
    logic [ELAPSED_W-1:0]        w_phase_ms;
    logic [ELAPSED_W-1:0]        w_idle_ms;

    // |goal*16 - now| <= tolerance, exact in 13 bits
    function automatic logic joint_ok(input logic [ANGLE_W-1:0] goal,
                                      input logic [FINE_W-1:0]  now,
                                      input logic [FINE_W-1:0]  tol);
        logic [FINE_W:0] diff;
        logic [FINE_W:0] mag;
        diff = {1'b0, goal, 4'b0000} - {1'b0, now};
        mag  = diff[FINE_W] ? (~diff + 1'b1) : diff;
        return mag <= {1'b0, tol};
    endfunction

    assign w_open  = i_cfg.grip_angles[ANGLE_W-1:0];
    assign w_close = i_cfg.grip_angles[2*ANGLE_W-1:ANGLE_W];

    // command latch and timeout fallback
    always_comb begin
        w_held    = i_item.cmd_valid | r_held;
        n_pick    = i_item.cmd_valid ?
                    {i_item.cmd_elbow, i_item.cmd_shoulder, i_item.cmd_base} : r_pick;
        w_timeout = r_phase_ms > {1'b0, i_cfg.state_timeout_ms};
        w_phase   = w_timeout ? PH_IDLE : r_phase;
        w_entry   = w_timeout | r_entry;
        w_sub     = ~w_timeout & r_sub;
    end

    // target angles and at-target checks
    always_comb begin
        w_goal_pose = r_goal;
        if (w_entry) begin
            case (w_phase)
                PH_READY: w_goal_pose = {w_open,  i_cfg.ready_pose};
                PH_LIFT:  w_goal_pose = {w_close, i_cfg.lift_pose};
                PH_PUT:   w_goal_pose = {w_close, i_cfg.put_pose};
                default:  w_goal_pose = r_goal;
            endcase
        end
        // reach follows the latest pick angles until the arm is there
        w_goal_aim = w_goal_pose;
        if (w_phase == PH_GRAB && !w_sub && w_held) begin
            w_goal_aim = {w_open, n_pick};
        end
        w_at[0] = joint_ok(w_goal_aim[0], i_item.now_base,     i_cfg.at_target_tolerance);
        w_at[1] = joint_ok(w_goal_aim[1], i_item.now_shoulder, i_cfg.at_target_tolerance);
        w_at[2] = joint_ok(w_goal_aim[2], i_item.now_elbow,    i_cfg.at_target_tolerance);
        w_at[3] = joint_ok(w_goal_aim[3], i_item.now_gripper,  i_cfg.at_target_tolerance);
        w_arm3  = &w_at[2:0];
        // arm in place: close the gripper, or open it when putting down
        n_goal = w_goal_aim;
        if (!w_sub && w_arm3 &&
            (w_phase == PH_GRAB || w_phase == PH_LIFT || w_phase == PH_PUT)) begin
            n_goal[3] = (w_phase == PH_PUT) ? w_open : w_close;
        end
    end

    // next phase, idle timer and pulse
    always_comb begin
        n_entry      = w_entry;
        n_sub        = w_sub;
        n_held       = w_held;
        n_idle_sent  = r_idle_sent;
        w_idle_ms    = r_idle_ms;
        w_phase_ms   = w_timeout ? '0 : r_phase_ms;
        w_go         = 1'b0;
        w_go_to      = PH_IDLE;
        w_start      = 1'b0;
        case (w_phase)
            PH_IDLE: begin
                n_entry = 1'b0;
                if (w_entry) begin
                    n_held      = 1'b0;
                    w_idle_ms   = '0;
                    w_start     = 1'b1;
                    n_idle_sent = 1'b1;
                end
                if (n_held) begin
                    w_go    = 1'b1;
                    w_go_to = PH_READY;
                end else if (n_idle_sent && w_idle_ms > {1'b0, i_cfg.idle_retry_ms}) begin
                    w_idle_ms = '0;
                    w_start   = 1'b1;
                end
            end
            PH_READY: begin
                n_entry = 1'b0;
                if (&w_at) begin
                    w_go    = 1'b1;
                    w_go_to = PH_GRAB;
                end
            end
            PH_GRAB, PH_LIFT, PH_PUT: begin
                n_entry = 1'b0;
                if (!w_sub) begin
                    if (w_arm3) begin
                        n_sub = 1'b1;
                    end
                end else if (w_at[3]) begin
                    w_go = 1'b1;
                    case (w_phase)
                        PH_GRAB: w_go_to = PH_LIFT;
                        PH_LIFT: w_go_to = PH_PUT;
                        default: w_go_to = PH_IDLE;
                    endcase
                end
            end
            default: begin
                w_go    = 1'b1;
                w_go_to = PH_IDLE;
            end
        endcase

        n_phase = w_phase;
        if (w_go) begin
            n_phase    = w_go_to;
            n_entry    = 1'b1;
            n_sub      = 1'b0;
            w_phase_ms = '0;
        end

        // request pulse: a trigger while high is ignored
        w_pulse_on   = r_pulse_on;
        w_pulse_left = r_pulse_left;
        if (w_start && !r_pulse_on) begin
            w_pulse_on   = 1'b1;
            w_pulse_left = i_cfg.pulse_length_ms;
        end
        if (w_pulse_on && w_pulse_left == '0) begin
            w_pulse_on = 1'b0;
        end
        n_pulse_on   = w_pulse_on;
        n_pulse_left = (w_pulse_on && w_pulse_left != '0) ? w_pulse_left - 1'b1
                                                          : w_pulse_left;

        // saturating elapsed counters
        n_phase_ms = (w_phase_ms == ELAPSED_MAX) ? w_phase_ms : w_phase_ms + 1'b1;
        n_idle_ms  = (w_idle_ms  == ELAPSED_MAX) ? w_idle_ms  : w_idle_ms  + 1'b1;
    end

    // result of this item
    always_comb begin
        o_result.goal_base     = n_goal[0];
        o_result.goal_shoulder = n_goal[1];
        o_result.goal_elbow    = n_goal[2];
        o_result.goal_gripper  = n_goal[3];
        o_result.arm_phase     = n_phase;
        o_result.request_level = n_pulse_on;
    end

    // state update, one item per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_entry      <= 1'b1;
            r_sub        <= 1'b0;
            r_held       <= 1'b0;
            r_idle_sent  <= 1'b0;
            r_pulse_on   <= 1'b0;
            r_pick       <= '0;
            r_goal       <= GOAL_RESET;
            r_phase_ms   <= '0;
            r_idle_ms    <= '0;
            r_pulse_left <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_entry      <= n_entry;
            r_sub        <= n_sub;
            r_held       <= n_held;
            r_idle_sent  <= n_idle_sent;
            r_pulse_on   <= n_pulse_on;
            r_pick       <= n_pick;
            r_goal       <= n_goal;
            r_phase_ms   <= n_phase_ms;
            r_idle_ms    <= n_idle_ms;
            r_pulse_left <= n_pulse_left;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pick_place_arm_sequencer_core.sv =====
`default_nettype none

// Pick-and-place arm sequencer. Each input item is one millisecond tick carrying an optional
// pick command and the present angles of the four servos; each item yields exactly one
// result item with the four target angles, the sequencer phase and the request line level.
// An item is registered on entry; the whole sequencer step is evaluated from that
// register and lands in the output register once that register is free or drains. One item
// is accepted every cycle while the output side keeps up. Registers are written over the
// APB port at byte address 4*i and should only be changed while no item is in flight.

module pick_place_arm_sequencer_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input item stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // cmd_base, cmd_shoulder, cmd_elbow, now_base, now_shoulder, now_elbow, now_gripper
    input  wire logic [ppas_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // cmd_valid
    input  wire logic [0:0]                         s_axis_tuser,
    // result item stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // goal_base, goal_shoulder, goal_elbow, goal_gripper, arm_phase, request_level, zero pad
    output logic [ppas_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ppas_pkg::APB_AW-1:0]        paddr,
    input  wire logic [ppas_pkg::APB_DW-1:0]        pwdata,
    output logic      [ppas_pkg::APB_DW-1:0]        prdata,
    output logic                                    pready
);
    import ppas_pkg::*;

    t_cfg    w_cfg;
    t_item   r_in;
    t_item   w_in;
    logic    r_in_valid;
    t_result r_out;
    t_result w_result;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_take;

    ppas_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ppas_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // unpack the input item
    always_comb begin
        w_in.cmd_valid    = s_axis_tuser[0];
        w_in.cmd_base     = s_axis_tdata[7:0];
        w_in.cmd_shoulder = s_axis_tdata[15:8];
        w_in.cmd_elbow    = s_axis_tdata[23:16];
        w_in.now_base     = s_axis_tdata[35:24];
        w_in.now_shoulder = s_axis_tdata[47:36];
        w_in.now_elbow    = s_axis_tdata[59:48];
        w_in.now_gripper  = s_axis_tdata[71:60];
    end

    // handshake: the input stage moves on whenever the output register is free or drains
    assign w_advance     = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_advance;
    assign w_take        = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= w_in;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.request_level, r_out.arm_phase,
                            r_out.goal_gripper, r_out.goal_elbow,
                            r_out.goal_shoulder, r_out.goal_base};

endmodule

`default_nettype wire

// ===== sv/ppas_checker.sv =====
`default_nettype none

`include "pick_place_arm_sequencer_core_macros.svh"

module ppas_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic [ppas_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input wire logic [0:0]                         s_axis_tuser,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [ppas_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input wire logic                               psel,
    input wire logic                               penable,
    input wire logic                               pwrite,
    input wire logic [ppas_pkg::APB_AW-1:0]        paddr,
    input wire logic [ppas_pkg::APB_DW-1:0]        pwdata,
    input wire logic [ppas_pkg::APB_DW-1:0]        prdata,
    input wire logic                               pready
);

    // reset empties both stages and opens the input
    `PPAS_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid && s_axis_tready, "pipeline not empty after reset")

    // a stalled result holds
    `PPAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n && m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // a taken item moves through the input register to the output when the sink is ready
    `PPAS_ASSERT_NEXT(a_item_latency, i_clk, (i_rst_n && s_axis_tvalid && s_axis_tready) ##1 (i_rst_n && m_axis_tready), m_axis_tvalid, "result missing after item")

    // padding bits above the result fields stay zero
    `PPAS_ASSERT_NOW(a_out_pad, i_clk, i_rst_n && m_axis_tvalid, m_axis_tdata[39:36] == 4'b0000, "result padding not zero")

endmodule

bind pick_place_arm_sequencer_core ppas_checker u_ppas_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ppas_pkg::*;

    localparam int QUIET_LIMIT = 500;
    localparam int PRINT_LIMIT = 50;

    // reference sequencer: holds the register copy, the arm state and the targets still owed
    class sequencer_scoreboard;
        t_cfg               cfg;
        t_phase             phase;
        bit                 entry_pending, sub_step, pick_held, idle_sent, pulse_on;
        logic [ANGLE_W-1:0] pick [3];
        logic [ANGLE_W-1:0] goal [4];
        logic [ELAPSED_W-1:0] phase_ms, idle_ms, pulse_left;
        t_result            expected_targets [$];
        int                 mismatch_count;
        int                 results_seen;

        function new();
            cfg = '0;
            cfg.at_target_tolerance = TOL_RESET;
            cfg.state_timeout_ms = TIMEOUT_RESET;
            cfg.idle_retry_ms = RETRY_RESET;
            cfg.pulse_length_ms = PULSE_RESET;
            phase = PH_IDLE;
            entry_pending = 1'b1;
            sub_step = 1'b0;
            pick_held = 1'b0;
            idle_sent = 1'b0;
            pulse_on = 1'b0;
            for (int j = 0; j < 3; j++) pick[j] = '0;
            for (int j = 0; j < 4; j++) goal[j] = GOAL_RESET[j];
            phase_ms = '0;
            idle_ms = '0;
            pulse_left = '0;
            mismatch_count = 0;
            results_seen = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [APB_DW-1:0] v);
            case (idx)
                REG_TOL:     cfg.at_target_tolerance = v[FINE_W-1:0];
                REG_TIMEOUT: cfg.state_timeout_ms = v[TIME_W-1:0];
                REG_RETRY:   cfg.idle_retry_ms = v[TIME_W-1:0];
                REG_PULSE:   cfg.pulse_length_ms = v[TIME_W-1:0];
                REG_READY:   cfg.ready_pose = v[POSE_W-1:0];
                REG_LIFT:    cfg.lift_pose = v[POSE_W-1:0];
                REG_PUT:     cfg.put_pose = v[POSE_W-1:0];
                REG_GRIP:    cfg.grip_angles = v[GRIP_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_targets.size();
        endfunction

        function void enter(t_phase p);
            phase = p;
            entry_pending = 1'b1;
            phase_ms = '0;
            sub_step = 1'b0;
        endfunction

        // joint error against the goal, in 1/16 degree
        function bit on_target(int j, logic [FINE_W-1:0] now_v);
            int err;
            err = int'(goal[j]) * 16 - int'(now_v);
            if (err < 0) err = -err;
            return err <= int'(cfg.at_target_tolerance);
        endfunction

        function void load_pose(logic [POSE_W-1:0] pose, logic [ANGLE_W-1:0] grip_v);
            goal[0] = pose[7:0];
            goal[1] = pose[15:8];
            goal[2] = pose[23:16];
            goal[3] = grip_v;
        endfunction

        function void fire_pulse();
            if (!pulse_on) begin
                pulse_on = 1'b1;
                pulse_left = cfg.pulse_length_ms;
            end
        endfunction

        // one millisecond tick taken by the block
        function void take_tick(t_item it);
            logic [ANGLE_W-1:0] g_open, g_close;
            bit arm_ok;
            t_result r;
            g_open = cfg.grip_angles[7:0];
            g_close = cfg.grip_angles[15:8];

            if (it.cmd_valid) begin
                pick[0] = it.cmd_base;
                pick[1] = it.cmd_shoulder;
                pick[2] = it.cmd_elbow;
                pick_held = 1'b1;
            end
            if (phase_ms > cfg.state_timeout_ms) enter(PH_IDLE);

            case (phase)
                PH_IDLE: begin
                    if (entry_pending) begin
                        entry_pending = 1'b0;
                        pick_held = 1'b0;
                        idle_ms = '0;
                        fire_pulse();
                        idle_sent = 1'b1;
                    end
                    if (pick_held) begin
                        enter(PH_READY);
                    end else if (idle_sent && idle_ms > cfg.idle_retry_ms) begin
                        idle_ms = '0;
                        fire_pulse();
                    end
                end
                PH_READY: begin
                    if (entry_pending) begin
                        entry_pending = 1'b0;
                        load_pose(cfg.ready_pose, g_open);
                    end
                    if (on_target(0, it.now_base) && on_target(1, it.now_shoulder) &&
                        on_target(2, it.now_elbow) && on_target(3, it.now_gripper))
                        enter(PH_GRAB);
                end
                PH_GRAB, PH_LIFT, PH_PUT: begin
                    if (entry_pending) begin
                        entry_pending = 1'b0;
                        sub_step = 1'b0;
                        if (phase == PH_LIFT) load_pose(cfg.lift_pose, g_close);
                        else if (phase == PH_PUT) load_pose(cfg.put_pose, g_close);
                    end
                    if (!sub_step) begin
                        // reach-grab follows the latest command until the arm is there
                        if (phase == PH_GRAB && pick_held) begin
                            goal[0] = pick[0];
                            goal[1] = pick[1];
                            goal[2] = pick[2];
                            goal[3] = g_open;
                        end
                        arm_ok = on_target(0, it.now_base) && on_target(1, it.now_shoulder) &&
                                 on_target(2, it.now_elbow);
                        if (arm_ok) begin
                            goal[3] = (phase == PH_PUT) ? g_open : g_close;
                            sub_step = 1'b1;
                        end
                    end else if (on_target(3, it.now_gripper)) begin
                        case (phase)
                            PH_GRAB: enter(PH_LIFT);
                            PH_LIFT: enter(PH_PUT);
                            default: enter(PH_IDLE);
                        endcase
                    end
                end
                default: enter(PH_IDLE);
            endcase

            if (pulse_on && pulse_left == 0) pulse_on = 1'b0;

            r.goal_base = goal[0];
            r.goal_shoulder = goal[1];
            r.goal_elbow = goal[2];
            r.goal_gripper = goal[3];
            r.arm_phase = phase;
            r.request_level = pulse_on;
            expected_targets.push_back(r);

            // counters advance after the result
            if (phase_ms != ELAPSED_MAX) phase_ms++;
            if (idle_ms != ELAPSED_MAX) idle_ms++;
            if (pulse_on && pulse_left != 0) pulse_left--;
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < PRINT_LIMIT) $display("%0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_targets(t_result got);
            t_result want;
            if (expected_targets.size() == 0) begin
                report_mismatch("result item with no tick waiting");
                return;
            end
            want = expected_targets.pop_front();
            if (got.goal_base !== want.goal_base)
                report_mismatch($sformatf("result %0d goal_base got %0d want %0d",
                                          results_seen, got.goal_base, want.goal_base));
            if (got.goal_shoulder !== want.goal_shoulder)
                report_mismatch($sformatf("result %0d goal_shoulder got %0d want %0d",
                                          results_seen, got.goal_shoulder, want.goal_shoulder));
            if (got.goal_elbow !== want.goal_elbow)
                report_mismatch($sformatf("result %0d goal_elbow got %0d want %0d",
                                          results_seen, got.goal_elbow, want.goal_elbow));
            if (got.goal_gripper !== want.goal_gripper)
                report_mismatch($sformatf("result %0d goal_gripper got %0d want %0d",
                                          results_seen, got.goal_gripper, want.goal_gripper));
            if (got.arm_phase !== want.arm_phase)
                report_mismatch($sformatf("result %0d arm_phase got %0d want %0d",
                                          results_seen, got.arm_phase, want.arm_phase));
            if (got.request_level !== want.request_level)
                report_mismatch($sformatf("result %0d request_level got %0d want %0d",
                                          results_seen, got.request_level, want.request_level));
            results_seen++;
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   psel, penable, pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    sequencer_scoreboard sb;
    t_item  cur_tick;
    bit     tick_taken;
    int     quiet_cycles = 0;
    int     tx_gap_pct = 0;
    int     rx_stall_pct = 0;

    pick_place_arm_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // handshake sampling, result checking and the no-progress watchdog
    always @(posedge i_clk) begin
        t_result got;
        bit      result_taken;
        tick_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        result_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (tick_taken) sb.take_tick(cur_tick);
        if (result_taken) begin
            got.goal_base = m_axis_tdata[7:0];
            got.goal_shoulder = m_axis_tdata[15:8];
            got.goal_elbow = m_axis_tdata[23:16];
            got.goal_gripper = m_axis_tdata[31:24];
            got.arm_phase = t_phase'(m_axis_tdata[34:32]);
            got.request_level = m_axis_tdata[35];
            sb.check_targets(got);
        end
        if (tick_taken || result_taken || (psel && penable && pwrite && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < rx_stall_pct) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(7, 1)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // tick with chosen command; masked joints sit within tolerance of the current goal
    function automatic t_item make_tick(bit cv, logic [7:0] cb, cs, ce, bit [3:0] near_mask);
        t_item it;
        int v;
        int tol;
        logic [FINE_W-1:0] now_v [4];
        tol = int'(sb.cfg.at_target_tolerance);
        for (int j = 0; j < 4; j++) begin
            if (near_mask[j]) begin
                v = int'(sb.goal[j]) * 16;
                case ($urandom_range(3))
                    0: v = v - tol;
                    1: v = v + tol;
                    default: v = v + int'($urandom_range(2 * tol)) - tol;
                endcase
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                now_v[j] = v[FINE_W-1:0];
            end else begin
                now_v[j] = $urandom_range(4095);
            end
        end
        it.cmd_valid = cv;
        it.cmd_base = cb;
        it.cmd_shoulder = cs;
        it.cmd_elbow = ce;
        it.now_base = now_v[0];
        it.now_shoulder = now_v[1];
        it.now_elbow = now_v[2];
        it.now_gripper = now_v[3];
        return it;
    endfunction

    function automatic logic [7:0] rand_angle();
        return ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(180);
    endfunction

    function automatic logic [POSE_W-1:0] rand_pose();
        return {8'($urandom_range(180)), 8'($urandom_range(180)), 8'($urandom_range(180))};
    endfunction

    // mostly ticks that let the sequence advance, some pure noise
    function automatic t_item random_tick();
        t_item it;
        bit [3:0] mask;
        int cmd_pct;
        if ($urandom_range(99) < 12) begin
            it.cmd_valid = $urandom_range(1);
            it.cmd_base = $urandom_range(255);
            it.cmd_shoulder = $urandom_range(255);
            it.cmd_elbow = $urandom_range(255);
            it.now_base = $urandom_range(4095);
            it.now_shoulder = $urandom_range(4095);
            it.now_elbow = $urandom_range(4095);
            it.now_gripper = $urandom_range(4095);
            return it;
        end
        cmd_pct = (sb.phase == PH_IDLE) ? 25 : 4;
        for (int j = 0; j < 4; j++) mask[j] = ($urandom_range(99) < 85);
        return make_tick($urandom_range(99) < cmd_pct, rand_angle(), rand_angle(),
                         rand_angle(), mask);
    endfunction

    // present one tick, holding it until taken
    task automatic send_tick(input t_item it);
        if ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge i_clk);
        end
        cur_tick = it;
        s_axis_tdata = {it.now_gripper, it.now_elbow, it.now_shoulder, it.now_base,
                        it.cmd_elbow, it.cmd_shoulder, it.cmd_base};
        s_axis_tuser = it.cmd_valid;
        s_axis_tvalid = 1'b1;
        do @(negedge i_clk); while (!tick_taken);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_tick(random_tick());
    endtask

    // stop sending and wait for every owed result
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic configure(input logic [FINE_W-1:0] tol, input logic [TIME_W-1:0] tmo,
                             input logic [TIME_W-1:0] retry, input logic [TIME_W-1:0] plen,
                             input logic [POSE_W-1:0] ready, input logic [POSE_W-1:0] lift,
                             input logic [POSE_W-1:0] put, input logic [GRIP_W-1:0] grip);
        drain();
        write_reg(REG_TOL, tol);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_RETRY, retry);
        write_reg(REG_PULSE, plen);
        write_reg(REG_READY, ready);
        write_reg(REG_LIFT, lift);
        write_reg(REG_PUT, put);
        write_reg(REG_GRIP, grip);
    endtask

    initial begin
        sb = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_tick = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed walk through one full pick and place on reset settings
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        // command on the idle entry tick is dropped, present angles at their top
        send_tick('{1'b1, 8'd180, 8'd180, 8'd180, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
        send_tick('0);
        send_tick('{1'b1, 8'd255, 8'd255, 8'd255, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b0000));
        // command during ready overwrites the held angles
        send_tick(make_tick(1'b1, 8'd0, 8'd180, 8'd90, 4'b1111));
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b0000));
        // reach-grab follows a late command
        send_tick(make_tick(1'b1, 8'd10, 8'd20, 8'd30, 4'b0000));
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b0111));
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b1000));
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b1111));
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b0111));
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b1000));
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b1111));
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b1111));
        send_tick(make_tick(1'b0, 8'd0, 8'd0, 8'd0, 4'b1111));
        send_tick(make_tick(1'b1, 8'd90, 8'd90, 8'd90, 4'b0000));

        // short timeouts and retries, with a full pause midway
        tx_gap_pct = 30;
        rx_stall_pct = 30;
        configure(12'd16, 16'd40, 16'd15, 16'd4, rand_pose(), rand_pose(), rand_pose(),
                  {8'($urandom_range(180)), 8'($urandom_range(180))});
        run_random(120);
        drain();
        run_random(130);

        // all zero: exact match, instant timeout, zero pulse length
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        configure('0, '0, '0, '0, rand_pose(), rand_pose(), rand_pose(), 16'h5A10);
        run_random(100);

        // widest timings and poses, tolerance of 180 degrees
        tx_gap_pct = 50;
        rx_stall_pct = 10;
        configure(12'd2880, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  16'hFFFF);
        run_random(150);

        tx_gap_pct = 10;
        rx_stall_pct = 50;
        configure(12'hFFF, 16'd1, 16'd1, 16'd1, '0, '0, '0, '0);
        run_random(100);

        // random settings
        for (int k = 0; k < 3; k++) begin
            tx_gap_pct = $urandom_range(40);
            rx_stall_pct = $urandom_range(40);
            configure($urandom_range(64), $urandom_range(200, 5), $urandom_range(50),
                      $urandom_range(20), rand_pose(), rand_pose(), rand_pose(),
                      {8'($urandom_range(180)), 8'($urandom_range(180))});
            run_random(260);
        end

        // closing stretch at full rate
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        configure($urandom_range(64), $urandom_range(200, 5), $urandom_range(50),
                  $urandom_range(20), rand_pose(), rand_pose(), rand_pose(),
                  {8'($urandom_range(180)), 8'($urandom_range(180))});
        run_random(250);

        drain();
        repeat (8) @(negedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/ppas_pkg.sv
sv/ppas_cfg.sv
sv/ppas_seq.sv
sv/pick_place_arm_sequencer_core.sv
sv/ppas_checker.sv
tb/sv/tb_top.sv
